// ===== rtl/tsps_pkg.sv =====
// Shared types and constants of the textured sphere pixel shader.
// Holds the transaction structs of both channels and the stage payloads.
// No dependencies.
package tsps_pkg;

	localparam int TEX_IDX_W = 15;
	localparam int MEM_DEPTH = 32768;
	localparam int PIX_ADDR_W = 18;

	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_SHADE = 1'b1;

	localparam logic [7:0] GLOW_THRESHOLD = 8'd10;
	localparam logic [5:0] BLUE_MAX = 6'd31;
	localparam logic [6:0] GREEN_MAX = 7'd63;

	typedef struct packed {
		logic action;
		logic [TEX_IDX_W-1:0] load_index;
		logic [15:0] load_texel;
		logic [7:0] column_base;
		logic [6:0] tex_row;
		logic [7:0] shade_factor;
		logic [7:0] glow_level;
		logic [8:0] screen_x;
		logic [8:0] screen_y;
		logic last_pixel;
	} tsps_item_t;

	typedef struct packed {
		logic [PIX_ADDR_W-1:0] pixel_address;
		logic [15:0] pixel_color;
		logic frame_end;
	} tsps_result_t;

	typedef struct packed {
		logic [7:0] shade;
		logic [7:0] glow;
		logic [PIX_ADDR_W-1:0] addr;
		logic last;
	} tsps_pix_t;

	typedef struct packed {
		logic action;
		logic [TEX_IDX_W-1:0] load_index;
		logic [15:0] load_texel;
		logic [TEX_IDX_W-1:0] tex_index;
		tsps_pix_t pix;
	} tsps_mid_t;

endpackage

// ===== rtl/textured_sphere_pixel_shader.sv =====
// Top level of the textured sphere pixel shader.
// Instantiates tsps_addr, tsps_ram and tsps_color; uses tsps_pkg.

// Takes one transaction per clock on the item channel while item_stall is low:
// a load writes one RGB565 texel into the 32768-entry texture memory and gives
// no result, a shade item presents one result on the result channel. Sustained
// rate, while the result channel does not stall, is one item per cycle, set by
// the single write and read port of the texture memory, which each item uses in stage two.
// Stalls on the result channel back up stage by stage, so empty stages keep
// accepting items. The texture memory has no reset: fill every entry that a shade
// item reads before shading. column_offset is written on the cfg channel, which
// is always ready; write it only while the pipeline is empty.
module textured_sphere_pixel_shader #(
	parameter int TEX_WIDTH = 256,
	parameter int TEX_HEIGHT = 128,
	parameter int SCREEN_STRIDE = 480
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [7:0] cfg_data,
	input logic item_valid,
	output logic item_stall,
	input tsps_pkg::tsps_item_t item,
	output logic result_valid,
	input logic result_stall,
	output tsps_pkg::tsps_result_t result
);
	import tsps_pkg::*;

	logic [7:0] column_offset_q;
	logic mid_valid, mid_ready, is_load;
	tsps_mid_t mid;
	logic color_valid, color_ready;
	logic ram_we, ram_re;
	logic [15:0] texel;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_offset_q <= 8'd0;
		end else if (cfg_valid && cfg_ready) begin
			column_offset_q <= cfg_data;
		end
	end

	tsps_addr #(
		.TEX_WIDTH(TEX_WIDTH),
		.TEX_HEIGHT(TEX_HEIGHT),
		.SCREEN_STRIDE(SCREEN_STRIDE)
	) u_addr (
		.clk(clk),
		.arst_n(arst_n),
		.column_offset(column_offset_q),
		.up_valid(item_valid),
		.up_stall(item_stall),
		.up_item(item),
		.dn_valid(mid_valid),
		.dn_ready(mid_ready),
		.dn_item(mid)
	);

	assign is_load = mid.action == ACT_LOAD;
	assign color_valid = mid_valid && !is_load;
	assign mid_ready = is_load || color_ready;
	assign ram_we = mid_valid && is_load;
	assign ram_re = color_valid && color_ready;

	tsps_ram #(
		.WIDTH(16),
		.DEPTH(MEM_DEPTH)
	) u_ram (
		.clk(clk),
		.we(ram_we),
		.waddr(mid.load_index),
		.wdata(mid.load_texel),
		.re(ram_re),
		.raddr(mid.tex_index),
		.rdata(texel)
	);

	tsps_color u_color (
		.clk(clk),
		.arst_n(arst_n),
		.up_valid(color_valid),
		.up_ready(color_ready),
		.up_pix(mid.pix),
		.texel(texel),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

endmodule

// ===== rtl/tsps_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module tsps_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32768
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic re,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/tsps_addr.sv =====
// Address stages: texture column wrap, texture index and framebuffer address.
// Two register stages with valid/ready flow; uses tsps_pkg.
module tsps_addr #(
	parameter int TEX_WIDTH = 256,
	parameter int TEX_HEIGHT = 128,
	parameter int SCREEN_STRIDE = 480
) (
	input logic clk,
	input logic arst_n,
	input logic [7:0] column_offset,
	input logic up_valid,
	output logic up_stall,
	input tsps_pkg::tsps_item_t up_item,
	output logic dn_valid,
	input logic dn_ready,
	output tsps_pkg::tsps_mid_t dn_item
);
	import tsps_pkg::*;

	localparam int UW = (TEX_WIDTH > 1) ? $clog2(TEX_WIDTH) : 1;
	localparam int CW = (UW + 1 > 10) ? UW + 1 : 10;
	localparam int RSH = 10;
	localparam int QPW = RSH + 9;
	localparam logic [RSH-1:0] RECIP = RSH'((1 << RSH) / TEX_WIDTH);
	localparam logic [6:0] ROW_MAX = (TEX_HEIGHT - 1 > 127) ? 7'd127 : 7'(TEX_HEIGHT - 1);

	logic rdy1, rdy2;
	logic [8:0] col_sum;
	logic [QPW-1:0] q_prod;
	logic [6:0] row_sat;
	logic [TEX_IDX_W-1:0] row_base;
	logic [PIX_ADDR_W-1:0] y_base;

	logic valid_s1;
	logic action_s1;
	logic [TEX_IDX_W-1:0] load_index_s1;
	logic [15:0] load_texel_s1;
	logic [8:0] col_sum_s1;
	logic [8:0] q_est_s1;
	logic [TEX_IDX_W-1:0] row_base_s1;
	logic [7:0] shade_s1;
	logic [7:0] glow_s1;
	logic [8:0] sx_s1;
	logic [PIX_ADDR_W-1:0] y_base_s1;
	logic last_s1;

	logic [CW-1:0] q_mul, rem0, rem1;
	logic [UW-1:0] col_u;

	logic valid_s2;
	tsps_mid_t mid_s2;

	assign rdy2 = !valid_s2 || dn_ready;
	assign rdy1 = !valid_s1 || rdy2;
	assign up_stall = !rdy1;

	assign col_sum = {1'b0, up_item.column_base} + {1'b0, column_offset};
	assign q_prod = QPW'(col_sum) * QPW'(RECIP);
	assign row_sat = (up_item.tex_row > ROW_MAX) ? ROW_MAX : up_item.tex_row;
	assign row_base = TEX_IDX_W'(32'(row_sat) * TEX_WIDTH);
	assign y_base = PIX_ADDR_W'(32'(up_item.screen_y) * SCREEN_STRIDE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rdy1) begin
			valid_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && up_valid) begin
			action_s1 <= up_item.action;
			load_index_s1 <= up_item.load_index;
			load_texel_s1 <= up_item.load_texel;
			col_sum_s1 <= col_sum;
			q_est_s1 <= q_prod[QPW-1:RSH];
			row_base_s1 <= row_base;
			shade_s1 <= up_item.shade_factor;
			glow_s1 <= up_item.glow_level;
			sx_s1 <= up_item.screen_x;
			y_base_s1 <= y_base;
			last_s1 <= up_item.last_pixel;
		end
	end

	assign q_mul = CW'(32'(q_est_s1) * TEX_WIDTH);
	assign rem0 = CW'(col_sum_s1) - q_mul;
	assign rem1 = (rem0 >= CW'(TEX_WIDTH)) ? rem0 - CW'(TEX_WIDTH) : rem0;
	assign col_u = rem1[UW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (rdy2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy2 && valid_s1) begin
			mid_s2.action <= action_s1;
			mid_s2.load_index <= load_index_s1;
			mid_s2.load_texel <= load_texel_s1;
			mid_s2.tex_index <= row_base_s1 + TEX_IDX_W'(col_u);
			mid_s2.pix.shade <= shade_s1;
			mid_s2.pix.glow <= glow_s1;
			mid_s2.pix.addr <= y_base_s1 + PIX_ADDR_W'(sx_s1);
			mid_s2.pix.last <= last_s1;
		end
	end

	assign dn_valid = valid_s2;
	assign dn_item = mid_s2;

endmodule

// ===== rtl/tsps_color.sv =====
// Color stages: texel channel scaling, rim glow with saturation, packing.
// Three register stages ending in the result register; uses tsps_pkg.
module tsps_color (
	input logic clk,
	input logic arst_n,
	input logic up_valid,
	output logic up_ready,
	input tsps_pkg::tsps_pix_t up_pix,
	input logic [15:0] texel,
	output logic result_valid,
	input logic result_stall,
	output tsps_pkg::tsps_result_t result
);
	import tsps_pkg::*;

	logic rdy3, rdy4, rdy5;

	logic valid_s3;
	tsps_pix_t pix_s3;

	logic [12:0] red_prod, blue_prod;
	logic [13:0] green_prod;

	logic valid_s4;
	logic [4:0] red_s4;
	logic [5:0] green_s4;
	logic [4:0] blue_s4;
	logic [7:0] glow_s4;
	logic [PIX_ADDR_W-1:0] addr_s4;
	logic last_s4;

	logic glow_on;
	logic [5:0] blue_sum;
	logic [6:0] green_sum;
	logic [4:0] blue_fin;
	logic [5:0] green_fin;

	logic valid_s5;
	tsps_result_t result_s5;

	assign rdy5 = !valid_s5 || !result_stall;
	assign rdy4 = !valid_s4 || rdy5;
	assign rdy3 = !valid_s3 || rdy4;
	assign up_ready = rdy3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (rdy3) begin
				valid_s3 <= up_valid;
			end
			if (rdy4) begin
				valid_s4 <= valid_s3;
			end
			if (rdy5) begin
				valid_s5 <= valid_s4;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy3 && up_valid) begin
			pix_s3 <= up_pix;
		end
	end

	assign red_prod = 13'(texel[15:11]) * 13'(pix_s3.shade);
	assign green_prod = 14'(texel[10:5]) * 14'(pix_s3.shade);
	assign blue_prod = 13'(texel[4:0]) * 13'(pix_s3.shade);

	always_ff @(posedge clk) begin
		if (rdy4 && valid_s3) begin
			red_s4 <= red_prod[12:8];
			green_s4 <= green_prod[13:8];
			blue_s4 <= blue_prod[12:8];
			glow_s4 <= pix_s3.glow;
			addr_s4 <= pix_s3.addr;
			last_s4 <= pix_s3.last;
		end
	end

	assign glow_on = glow_s4 > GLOW_THRESHOLD;
	assign blue_sum = {1'b0, blue_s4} + 6'(glow_s4[7:4]);
	assign green_sum = {1'b0, green_s4} + 7'(glow_s4[7:5]);

	always_comb begin
		blue_fin = blue_s4;
		green_fin = green_s4;
		if (glow_on) begin
			blue_fin = (blue_sum > BLUE_MAX) ? BLUE_MAX[4:0] : blue_sum[4:0];
			green_fin = (green_sum > GREEN_MAX) ? GREEN_MAX[5:0] : green_sum[5:0];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy5 && valid_s4) begin
			result_s5.pixel_address <= addr_s4;
			result_s5.pixel_color <= {red_s4, green_fin, blue_fin};
			result_s5.frame_end <= last_s4;
		end
	end

	assign result_valid = valid_s5;
	assign result = result_s5;

endmodule

// ===== test/tsps_shade_checker.sv =====
`timescale 1ns / 1ps
// Shading checker for the textured sphere pixel shader testbench.
// Watches the cfg, item and result channels, predicts every pixel and compares in order.
// Depends on tsps_pkg.
module tsps_shade_checker #(
	parameter int TEX_WIDTH = 256,
	parameter int TEX_HEIGHT = 128,
	parameter int SCREEN_STRIDE = 480
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_valid,
	input logic cfg_ready,
	input logic [7:0] cfg_data,
	input logic item_valid,
	input logic item_stall,
	input tsps_pkg::tsps_item_t item,
	input logic result_valid,
	input logic result_stall,
	input tsps_pkg::tsps_result_t result,
	output int failures,
	output int pending
);
	import tsps_pkg::*;

	logic [15:0] texture_copy [MEM_DEPTH];
	logic [7:0] lon_offset;
	tsps_result_t expected_pixels [$];
	tsps_result_t want;
	int errors;

	initial begin
		errors = 0;
	end

	function automatic tsps_result_t shade_pixel(input tsps_item_t it);
		int unsigned row;
		int unsigned col;
		int unsigned tidx;
		int unsigned texel;
		int unsigned red;
		int unsigned green;
		int unsigned blue;
		int unsigned addr;
		tsps_result_t res;
		row = it.tex_row;
		if (row > TEX_HEIGHT - 1)
			row = TEX_HEIGHT - 1;
		col = (it.column_base + lon_offset) % TEX_WIDTH;
		tidx = (row * TEX_WIDTH + col) % MEM_DEPTH;
		texel = texture_copy[tidx];
		red = (((texel >> 11) & 32'h1F) * it.shade_factor) >> 8;
		green = (((texel >> 5) & 32'h3F) * it.shade_factor) >> 8;
		blue = ((texel & 32'h1F) * it.shade_factor) >> 8;
		if (it.glow_level > GLOW_THRESHOLD) begin
			blue = blue + (it.glow_level >> 4);
			green = green + (it.glow_level >> 5);
			if (blue > BLUE_MAX)
				blue = BLUE_MAX;
			if (green > GREEN_MAX)
				green = GREEN_MAX;
		end
		addr = (it.screen_y * SCREEN_STRIDE + it.screen_x) % (1 << PIX_ADDR_W);
		res.pixel_address = addr[PIX_ADDR_W-1:0];
		res.pixel_color = {red[4:0], green[5:0], blue[4:0]};
		res.frame_end = it.last_pixel;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lon_offset = '0;
			expected_pixels.delete();
		end else begin
			if (cfg_valid && cfg_ready)
				lon_offset = cfg_data;
			if (result_valid && !result_stall) begin
				if (expected_pixels.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual %h", $time, result);
					errors++;
				end else begin
					want = expected_pixels.pop_front();
					if (result.pixel_address !== want.pixel_address) begin
						$display("%0t: pixel_address expected %h actual %h", $time,
							want.pixel_address, result.pixel_address);
						errors++;
					end
					if (result.pixel_color !== want.pixel_color) begin
						$display("%0t: pixel_color expected %h actual %h", $time,
							want.pixel_color, result.pixel_color);
						errors++;
					end
					if (result.frame_end !== want.frame_end) begin
						$display("%0t: frame_end expected %b actual %b", $time,
							want.frame_end, result.frame_end);
						errors++;
					end
				end
			end
			if (item_valid && !item_stall) begin
				if (item.action == ACT_LOAD)
					texture_copy[item.load_index] = item.load_texel;
				else
					expected_pixels.insert(expected_pixels.size(), shade_pixel(item));
			end
		end
		failures <= errors;
		pending <= expected_pixels.size();
	end

endmodule

// ===== test/textured_sphere_pixel_shader_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the textured sphere pixel shader: clock, reset, stimulus and verdict.
// Depends on tsps_pkg, textured_sphere_pixel_shader and tsps_shade_checker.
module textured_sphere_pixel_shader_tb;
	import tsps_pkg::*;

	localparam int TEX_WIDTH = 256;
	localparam int TEX_HEIGHT = 128;
	localparam int SCREEN_STRIDE = 480;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 16;

	logic clk;
	logic arst_n = 1'b0;
	logic cfg_valid;
	logic cfg_ready;
	logic [7:0] cfg_data;
	logic item_valid;
	logic item_stall;
	tsps_item_t item;
	logic result_valid;
	logic result_stall = 1'b0;
	tsps_result_t result;
	int failures;
	int pending;

	logic calm = 1'b0;
	int stall_left = 0;
	int quiet_left = 0;
	int idle_cycles = 0;
	int filled [$];
	int last_loaded = 0;
	logic [7:0] cur_offset = '0;

	textured_sphere_pixel_shader #(
		.TEX_WIDTH(TEX_WIDTH),
		.TEX_HEIGHT(TEX_HEIGHT),
		.SCREEN_STRIDE(SCREEN_STRIDE)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	tsps_shade_checker #(
		.TEX_WIDTH(TEX_WIDTH),
		.TEX_HEIGHT(TEX_HEIGHT),
		.SCREEN_STRIDE(SCREEN_STRIDE)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.failures(failures),
		.pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (!arst_n || calm) begin
			result_stall <= 1'b0;
			stall_left <= 0;
		end else if (stall_left > 0) begin
			result_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else if (quiet_left > 0) begin
			result_stall <= 1'b0;
			quiet_left <= quiet_left - 1;
		end else if ($urandom_range(0, 39) == 0) begin
			result_stall <= 1'b0;
			quiet_left <= $urandom_range(20, 60);
		end else if ($urandom_range(0, 5) == 0) begin
			result_stall <= 1'b1;
			stall_left <= $urandom_range(0, 7);
		end else begin
			result_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (item_valid && !item_stall) || (result_valid && !result_stall) ||
				(cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("textured_sphere_pixel_shader: mismatch");
			$finish;
		end
	end

	function automatic tsps_item_t noise_item();
		logic [95:0] raw;
		raw = {$urandom, $urandom, $urandom};
		return raw[$bits(tsps_item_t)-1:0];
	endfunction

	task automatic push(input tsps_item_t it);
		if (!calm && $urandom_range(0, 4) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		item <= it;
		item_valid <= 1'b1;
		@(posedge clk);
		while (item_stall) @(posedge clk);
	endtask

	task automatic load_at(input int idx, input logic [15:0] texel);
		tsps_item_t it;
		it = noise_item();
		it.action = ACT_LOAD;
		it.load_index = idx[TEX_IDX_W-1:0];
		it.load_texel = texel;
		filled.insert(filled.size(), idx);
		last_loaded = idx;
		push(it);
	endtask

	task automatic shade_at(input int idx, input int shade, input int glow,
			input int x, input int y, input logic last);
		tsps_item_t it;
		int col;
		it = noise_item();
		col = ((idx % TEX_WIDTH) - cur_offset + TEX_WIDTH) % TEX_WIDTH;
		it.action = ACT_SHADE;
		it.tex_row = 7'(idx / TEX_WIDTH);
		it.column_base = 8'(col);
		it.shade_factor = 8'(shade);
		it.glow_level = 8'(glow);
		it.screen_x = 9'(x);
		it.screen_y = 9'(y);
		it.last_pixel = last;
		push(it);
	endtask

	task automatic write_offset(input logic [7:0] value);
		cfg_data <= value;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		cur_offset = value;
	endtask

	task automatic settle();
		item_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic run_random(input int count);
		int idx;
		int x;
		int y;
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(0, 2) == 0) begin
				load_at($urandom_range(0, TEX_WIDTH * TEX_HEIGHT - 1), 16'($urandom));
			end else begin
				if ($urandom_range(0, 3) == 0)
					idx = last_loaded;
				else
					idx = filled[$urandom_range(0, filled.size() - 1)];
				if ($urandom_range(0, 15) == 0) begin
					x = $urandom_range(0, 511);
					y = $urandom_range(0, 511);
				end else begin
					x = $urandom_range(0, 479);
					y = $urandom_range(0, 479);
				end
				shade_at(idx, $urandom_range(0, 255), $urandom_range(0, 255), x, y,
					$urandom_range(0, 7) == 0);
			end
		end
	endtask

	initial begin
		cfg_valid = 1'b0;
		cfg_data = '0;
		item_valid = 1'b0;
		item = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_offset(8'd0);
		load_at(0, 16'hFFFF);
		load_at(32767, 16'hFFFF);
		load_at(1, 16'h0000);
		load_at(256, 16'hF800);
		load_at(512, 16'h07E0);
		load_at(768, 16'h001F);
		shade_at(0, 255, 255, 479, 479, 1'b1);
		shade_at(32767, 0, 0, 0, 0, 1'b0);
		shade_at(1, 255, 10, 100, 200, 1'b0);
		shade_at(1, 255, 11, 200, 100, 1'b0);
		shade_at(1, 0, 255, 300, 1, 1'b0);
		shade_at(256, 128, 0, 1, 300, 1'b0);
		shade_at(512, 200, 100, 17, 33, 1'b0);
		shade_at(768, 255, 240, 470, 5, 1'b0);
		shade_at(0, 255, 0, 511, 511, 1'b1);
		load_at(0, 16'h1234);
		shade_at(0, 255, 0, 2, 2, 1'b0);
		settle();

		write_offset(8'd255);
		shade_at(0, 255, 0, 3, 3, 1'b0);
		shade_at(32767, 255, 255, 4, 4, 1'b1);
		run_random(140);
		settle();
		write_offset(8'd128);
		run_random(140);
		settle();
		write_offset(8'($urandom_range(1, 254)));
		run_random(140);
		settle();
		write_offset(8'd1);
		run_random(140);
		settle();
		write_offset(8'($urandom_range(0, 255)));
		calm = 1'b1;
		run_random(170);
		settle();

		if (failures == 0 && pending == 0)
			$display("textured_sphere_pixel_shader: match");
		else
			$display("textured_sphere_pixel_shader: mismatch");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/tsps_pkg.sv
rtl/tsps_ram.sv
rtl/tsps_addr.sv
rtl/tsps_color.sv
rtl/textured_sphere_pixel_shader.sv
test/tsps_shade_checker.sv
test/textured_sphere_pixel_shader_tb.sv
